@@ rtl/core/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants for the barometer compensation block
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CfgCoeffASigned   = 3'd0,
		CfgCoeffAUnsigned = 3'd1,
		CfgCoeffB         = 3'd2,
		CfgCoeffM         = 3'd3,
		CfgOversampling   = 3'd4
	} cfg_index_t;

	localparam logic ActTemperature = 1'b0;
	localparam logic ActPressure    = 1'b1;

	localparam logic signed [WordW-1:0] TempOffset   = 32'sd4000;
	localparam logic [WordW-1:0]        B4Bias       = 32'd32768;
	localparam logic [WordW-1:0]        B7Scale      = 32'd50000;
	localparam logic signed [WordW-1:0] PolyC1       = 32'sd3038;
	localparam logic signed [WordW-1:0] PolyC2       = -32'sd7357;
	localparam logic signed [WordW-1:0] PolyC3       = 32'sd3791;
	localparam logic signed [WordW-1:0] TempRound    = 32'sd8;
	localparam logic signed [WordW-1:0] TempScale    = 32'sd10;

	// divider handshake
	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		word_t quotient;
	} div_rsp_t;

endpackage

@@ rtl/core/psc_div.sv @@
// ----------------------------------------------------------------------------
// psc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  psc_pkg::div_req_t   req,
	output psc_pkg::div_rsp_t   rsp
);

	localparam int unsigned CntW = $clog2(psc_pkg::WordW);

	logic [psc_pkg::WordW:0]   rem_q;
	psc_pkg::word_t            quo_q;
	psc_pkg::word_t            dvs_q;
	logic [CntW-1:0]           cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [psc_pkg::WordW:0]   rem_sh;
	logic [psc_pkg::WordW:0]   rem_sub;

	assign rem_sh  = {rem_q[psc_pkg::WordW-1:0], quo_q[psc_pkg::WordW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(psc_pkg::WordW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!rem_sub[psc_pkg::WordW]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[psc_pkg::WordW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[psc_pkg::WordW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ rtl/core/pressure_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// integer temperature and pressure compensation of a digital barometer
// ----------------------------------------------------------------------------
// channel  direction  handshake             beat
// in       sink       in_valid / in_stall   action, raw_sample
// out      source     out_valid / out_stall kind, value, div_error
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// accept to result loaded: temperature via S_T0-S_T2, 32-step divider, S_T4,
// S_FIN; pressure via S_P0-S_P7, the divider, S_P9-S_P11, S_FIN; a zero divisor
// skips the divider; each product is one step of the shared 32x32 multiplier
// one item at a time: in_stall is high from accept until the result is loaded
// into the output register, which then holds it while out_stall is high
// reset clears the kept temperature term and all calibration registers
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic         action,
	input  logic [23:0]  raw_sample,
	output logic         out_valid,
	input  logic         out_stall,
	output logic         kind,
	output logic signed [31:0] value,
	output logic         div_error,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [47:0]  cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_T0, S_T1, S_T2, S_TDIV, S_T4, S_T5,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_PDIV,
		S_P9, S_P10, S_P11, S_FIN
	} state_t;

	state_t state_q;

	logic [47:0] cas_q;
	logic [47:0] cau_q;
	logic [31:0] cb_q;
	logic [31:0] cm_q;
	logic [1:0]  oss_q;
	logic signed [31:0] temp_term_q;

	logic [23:0] raw_q;
	logic signed [31:0] mul_a_q, mul_b_q;
	logic signed [31:0] x1_q, b6_q, sq_q, b3_q, p_q;
	logic [31:0]        b4_q;
	logic               neg_q, dbl_q;
	logic               div_start_q;
	logic [31:0]        div_dividend_q, div_divisor_q;

	logic               res_kind_q, res_err_q;
	logic signed [31:0] res_value_q;
	logic               out_valid_q, kind_q, div_error_q;
	logic signed [31:0] value_q;

	psc_pkg::div_req_t  div_req;
	psc_pkg::div_rsp_t  div_rsp;

	// calibration words
	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [31:0]        ac4, ac5, ac6;

	assign ac1 = {{16{cas_q[47]}}, cas_q[47:32]};
	assign ac2 = {{16{cas_q[31]}}, cas_q[31:16]};
	assign ac3 = {{16{cas_q[15]}}, cas_q[15:0]};
	assign ac4 = {16'd0, cau_q[47:32]};
	assign ac5 = {16'd0, cau_q[31:16]};
	assign ac6 = {16'd0, cau_q[15:0]};
	assign b1  = {{16{cb_q[31]}}, cb_q[31:16]};
	assign b2  = {{16{cb_q[15]}}, cb_q[15:0]};
	assign mc  = {{16{cm_q[31]}}, cm_q[31:16]};
	assign md  = {{16{cm_q[15]}}, cm_q[15:0]};

	// shared multiplier, low 32 bits
	logic signed [31:0] prod;
	assign prod = mul_a_q * mul_b_q;

	// temperature helpers
	logic signed [31:0] t_den, t_num, t_x2, t_b5;
	assign t_den = x1_q + md;
	assign t_num = mc <<< 11;
	assign t_x2  = neg_q ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
	assign t_b5  = x1_q + t_x2;

	// pressure helpers
	logic signed [31:0] p_b3a, p_b3b, p_x3, p_b6;
	logic [31:0]        p_up, p_b4, p_quo;
	assign p_b6  = temp_term_q - psc_pkg::TempOffset;
	assign p_b3a = (ac1 <<< 2) + x1_q + (prod >>> 11);
	assign p_b3b = p_b3a <<< oss_q;
	assign p_x3  = (x1_q + (prod >>> 16) + 32'sd2) >>> 2;
	assign p_up  = {8'd0, raw_q >> (4'd8 - {2'd0, oss_q})};
	assign p_b4  = $unsigned(prod) >> 15;
	assign p_quo = dbl_q ? {div_rsp.quotient[30:0], 1'b0} : div_rsp.quotient;

	logic out_take;
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cas_q <= '0;
			cau_q <= '0;
			cb_q  <= '0;
			cm_q  <= '0;
			oss_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psc_pkg::CfgCoeffASigned:   cas_q <= cfg_data;
				psc_pkg::CfgCoeffAUnsigned: cau_q <= cfg_data;
				psc_pkg::CfgCoeffB:         cb_q  <= cfg_data[31:0];
				psc_pkg::CfgCoeffM:         cm_q  <= cfg_data[31:0];
				psc_pkg::CfgOversampling:   oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			temp_term_q <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the final state reloads the output register itself
			if (out_take && state_q != S_FIN) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						raw_q   <= raw_sample;
						state_q <= (action == psc_pkg::ActPressure) ? S_P0 : S_T0;
					end
				end
				S_T0: begin
					mul_a_q <= $signed({16'd0, raw_q[15:0]} - ac6);
					mul_b_q <= $signed(ac5);
					state_q <= S_T1;
				end
				S_T1: begin
					x1_q    <= prod >>> 15;
					state_q <= S_T2;
				end
				S_T2: begin
					res_kind_q <= psc_pkg::ActTemperature;
					if (t_den == '0) begin
						res_value_q <= '0;
						res_err_q   <= 1'b1;
						state_q     <= S_FIN;
					end else begin
						div_dividend_q <= t_num[31] ? $unsigned(-t_num) : $unsigned(t_num);
						div_divisor_q  <= t_den[31] ? $unsigned(-t_den) : $unsigned(t_den);
						neg_q          <= t_num[31] ^ t_den[31];
						div_start_q    <= 1'b1;
						state_q        <= S_TDIV;
					end
				end
				S_TDIV: begin
					div_start_q <= 1'b0;
					if (div_rsp.done) begin
						temp_term_q <= t_b5;
						mul_a_q     <= (t_b5 + psc_pkg::TempRound) >>> 4;
						mul_b_q     <= psc_pkg::TempScale;
						state_q     <= S_T4;
					end
				end
				S_T4: begin
					res_value_q <= prod;
					res_err_q   <= 1'b0;
					state_q     <= S_FIN;
				end
				S_T5: state_q <= S_FIN;
				S_P0: begin
					b6_q    <= p_b6;
					mul_a_q <= p_b6;
					mul_b_q <= p_b6;
					state_q <= S_P1;
				end
				S_P1: begin
					sq_q    <= prod >>> 12;
					mul_a_q <= b2;
					mul_b_q <= prod >>> 12;
					state_q <= S_P2;
				end
				S_P2: begin
					x1_q    <= prod >>> 11;
					mul_a_q <= ac2;
					mul_b_q <= b6_q;
					state_q <= S_P3;
				end
				S_P3: begin
					b3_q    <= (p_b3b + 32'sd2) >>> 2;
					mul_a_q <= ac3;
					mul_b_q <= b6_q;
					state_q <= S_P4;
				end
				S_P4: begin
					x1_q    <= prod >>> 13;
					mul_a_q <= b1;
					mul_b_q <= sq_q;
					state_q <= S_P5;
				end
				S_P5: begin
					mul_a_q <= $signed(ac4);
					mul_b_q <= p_x3 + $signed(psc_pkg::B4Bias);
					state_q <= S_P6;
				end
				S_P6: begin
					res_kind_q <= psc_pkg::ActPressure;
					b4_q       <= p_b4;
					if (p_b4 == '0) begin
						res_value_q <= '0;
						res_err_q   <= 1'b1;
						state_q     <= S_FIN;
					end else begin
						mul_a_q <= $signed(p_up) - b3_q;
						mul_b_q <= $signed(psc_pkg::B7Scale >> oss_q);
						state_q <= S_P7;
					end
				end
				S_P7: begin
					// large b7 divides first and doubles after
					dbl_q          <= prod[31];
					div_dividend_q <= prod[31] ? $unsigned(prod) : {prod[30:0], 1'b0};
					div_divisor_q  <= b4_q;
					div_start_q    <= 1'b1;
					state_q        <= S_PDIV;
				end
				S_PDIV: begin
					div_start_q <= 1'b0;
					if (div_rsp.done) begin
						p_q     <= $signed(p_quo);
						mul_a_q <= $signed(p_quo) >>> 8;
						mul_b_q <= $signed(p_quo) >>> 8;
						state_q <= S_P9;
					end
				end
				S_P9: begin
					mul_a_q <= prod;
					mul_b_q <= psc_pkg::PolyC1;
					state_q <= S_P10;
				end
				S_P10: begin
					x1_q    <= prod >>> 16;
					mul_a_q <= p_q;
					mul_b_q <= psc_pkg::PolyC2;
					state_q <= S_P11;
				end
				S_P11: begin
					res_value_q <= p_q + ((x1_q + (prod >>> 16) + psc_pkg::PolyC3) >>> 4);
					res_err_q   <= 1'b0;
					state_q     <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						kind_q      <= res_kind_q;
						value_q     <= res_value_q;
						div_error_q <= res_err_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dividend_q;
	assign div_req.divisor  = div_divisor_q;

	psc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign div_error = div_error_q;
	assign cfg_ready = 1'b1;

endmodule
